### sv/ccnd_pkg.sv
package ccnd_pkg;

	// field widths
	localparam int COORD_W = 12;
	localparam int PIXEL_W = 16;
	localparam int INDEX_W = 12;
	localparam int DIM_W   = 12;

	// configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [DIM_W-1:0]     DIM_RESET        = 12'd64;

	// default thumbnail side
	localparam int OUT_SIDE_DEF = 64;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [DIM_W-1:0]   dim_t;

	typedef struct packed {
		coord_t src_x;
		coord_t src_y;
		pixel_t pixel_value;
	} in_item_t;

	typedef struct packed {
		index_t dest_index;
		pixel_t dest_pixel;
	} out_item_t;

endpackage

### sv/ccnd_cell.sv
module ccnd_cell import ccnd_pkg::*; #(
	parameter int QW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dim_t          side,
	input  logic          in_vld,
	output logic          in_rdy,
	input  pixel_t        in_pix,
	input  dim_t          in_rem_x,
	input  dim_t          in_rem_y,
	input  logic [QW-1:0] in_num_x,
	input  logic [QW-1:0] in_num_y,
	input  logic [QW-1:0] in_quo_x,
	input  logic [QW-1:0] in_quo_y,
	output logic          out_vld,
	input  logic          out_rdy,
	output pixel_t        out_pix,
	output dim_t          out_rem_x,
	output dim_t          out_rem_y,
	output logic [QW-1:0] out_num_x,
	output logic [QW-1:0] out_num_y,
	output logic [QW-1:0] out_quo_x,
	output logic [QW-1:0] out_quo_y
);

	logic          vld_q;
	pixel_t        pix_q;
	dim_t          rem_x_q, rem_y_q;
	logic [QW-1:0] num_x_q, num_y_q, quo_x_q, quo_y_q;

	logic [DIM_W:0] r2_x, r2_y, side_ext;
	logic           ge_x, ge_y;
	dim_t           nrem_x, nrem_y;

	// one restoring division step per axis
	always_comb begin
		side_ext = {1'b0, side};
		r2_x     = {in_rem_x, in_num_x[QW-1]};
		r2_y     = {in_rem_y, in_num_y[QW-1]};
		ge_x     = r2_x >= side_ext;
		ge_y     = r2_y >= side_ext;
		nrem_x   = ge_x ? DIM_W'(r2_x - side_ext) : r2_x[DIM_W-1:0];
		nrem_y   = ge_y ? DIM_W'(r2_y - side_ext) : r2_y[DIM_W-1:0];
	end

	// cell can take a new item when empty or when its contents move on
	assign in_rdy = !vld_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			pix_q   <= in_pix;
			rem_x_q <= nrem_x;
			rem_y_q <= nrem_y;
			num_x_q <= {in_num_x[QW-2:0], 1'b0};
			num_y_q <= {in_num_y[QW-2:0], 1'b0};
			quo_x_q <= {in_quo_x[QW-2:0], ge_x};
			quo_y_q <= {in_quo_y[QW-2:0], ge_y};
		end
	end

	assign out_vld   = vld_q;
	assign out_pix   = pix_q;
	assign out_rem_x = rem_x_q;
	assign out_rem_y = rem_y_q;
	assign out_num_x = num_x_q;
	assign out_num_y = num_y_q;
	assign out_quo_x = quo_x_q;
	assign out_quo_y = quo_y_q;

endmodule

### sv/center_crop_nearest_downscaler.sv
// pipeline: the crop stage loads a pixel at the accepting edge, then one division cell per
//   quotient bit, then one output register
// throughput: one pixel per cycle while out_ready does not stall the chain; each division
//   cell retires one quotient bit for both axes
// reset: image_width and image_height return to 64, pipeline and output register empty
module center_crop_nearest_downscaler import ccnd_pkg::*; #(
	parameter int OUT_SIDE = OUT_SIDE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  dim_t                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	localparam int QW = $clog2(OUT_SIDE);
	localparam int NW = DIM_W + QW;
	localparam int IW = 2 * QW + 1;

	// configuration registers
	dim_t width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// crop geometry
	dim_t           side, off_x, off_y;
	logic [DIM_W:0] end_x, end_y;
	logic           hit;
	dim_t           r_x, r_y;
	logic [NW-1:0]  n_x, n_y;

	always_comb begin
		side  = (width_q < height_q) ? width_q : height_q;
		off_x = (width_q - side) >> 1;
		off_y = (height_q - side) >> 1;
		end_x = {1'b0, off_x} + {1'b0, side};
		end_y = {1'b0, off_y} + {1'b0, side};
		hit   = (side != '0)
			&& (in_data.src_x >= off_x) && ({1'b0, in_data.src_x} < end_x)
			&& (in_data.src_y >= off_y) && ({1'b0, in_data.src_y} < end_y);
		r_x   = in_data.src_x - off_x;
		r_y   = in_data.src_y - off_y;
		n_x   = NW'(r_x) * NW'(OUT_SIDE);
		n_y   = NW'(r_y) * NW'(OUT_SIDE);
	end

	// chain links: element 0 is the crop stage, element k the output of cell k-1
	logic          vld [QW+1];
	logic          rdy [QW+1];
	pixel_t        pix [QW+1];
	dim_t          rem_x [QW+1];
	dim_t          rem_y [QW+1];
	logic [QW-1:0] num_x [QW+1];
	logic [QW-1:0] num_y [QW+1];
	logic [QW-1:0] quo_x [QW+1];
	logic [QW-1:0] quo_y [QW+1];

	// crop stage; pixels outside the crop leave no entry
	logic          s0_vld_q;
	pixel_t        pix_s1;
	dim_t          rem_x_s1, rem_y_s1;
	logic [QW-1:0] num_x_s1, num_y_s1;

	assign in_ready = !s0_vld_q || rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_vld_q <= 1'b0;
		end else if (in_ready) begin
			s0_vld_q <= in_valid && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pix_s1   <= in_data.pixel_value;
			rem_x_s1 <= n_x[NW-1:QW];
			rem_y_s1 <= n_y[NW-1:QW];
			num_x_s1 <= n_x[QW-1:0];
			num_y_s1 <= n_y[QW-1:0];
		end
	end

	assign vld[0]   = s0_vld_q;
	assign pix[0]   = pix_s1;
	assign rem_x[0] = rem_x_s1;
	assign rem_y[0] = rem_y_s1;
	assign num_x[0] = num_x_s1;
	assign num_y[0] = num_y_s1;
	assign quo_x[0] = '0;
	assign quo_y[0] = '0;

	// division cells, one quotient bit each
	for (genvar k = 0; k < QW; k++) begin : g_cell
		ccnd_cell #(.QW(QW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.side      (side),
			.in_vld    (vld[k]),
			.in_rdy    (rdy[k]),
			.in_pix    (pix[k]),
			.in_rem_x  (rem_x[k]),
			.in_rem_y  (rem_y[k]),
			.in_num_x  (num_x[k]),
			.in_num_y  (num_y[k]),
			.in_quo_x  (quo_x[k]),
			.in_quo_y  (quo_y[k]),
			.out_vld   (vld[k+1]),
			.out_rdy   (rdy[k+1]),
			.out_pix   (pix[k+1]),
			.out_rem_x (rem_x[k+1]),
			.out_rem_y (rem_y[k+1]),
			.out_num_x (num_x[k+1]),
			.out_num_y (num_y[k+1]),
			.out_quo_x (quo_x[k+1]),
			.out_quo_y (quo_y[k+1])
		);
	end

	// output register with thumbnail index
	logic          out_valid_q;
	out_item_t     out_data_q;
	logic [IW-1:0] idx_full;

	assign rdy[QW]  = !out_valid_q || out_ready;
	assign idx_full = IW'(quo_y[QW]) * IW'(OUT_SIDE) + IW'(quo_x[QW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[QW]) begin
			out_valid_q <= vld[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[QW] && vld[QW]) begin
			out_data_q.dest_index <= INDEX_W'(idx_full);
			out_data_q.dest_pixel <= pix[QW];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a partial remainder entering the chain stays below the crop side
	assert property (@(posedge clk) disable iff (!arst_n)
		s0_vld_q |-> (rem_x_s1 < side) && (rem_y_s1 < side))
	else $error("partial remainder not below crop side");

	// an empty crop never yields a transfer into the chain
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && side == '0) |=> !s0_vld_q)
	else $error("pixel entered chain with zero crop side");

	// input stalls only when a result is held at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
	else $error("input stalled without output backpressure");

endmodule

### verif/center_crop_nearest_downscaler_tb.sv
`timescale 1ns / 1ps

module center_crop_nearest_downscaler_tb;
	import ccnd_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 7;
	localparam int THUMB_SIDE     = OUT_SIDE_DEF;
	localparam int PIPE_LATENCY   = $clog2(THUMB_SIDE) + 1;
	localparam int DRAIN_CYCLES   = PIPE_LATENCY + 8;
	localparam int IDLE_PCT       = 35;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 200;
	localparam int SCRIPT_LEN     = 35;
	localparam int TIMEOUT_CYCLES = 400000;

	// register index that maps to nothing, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {STEP_PIXEL, STEP_CONFIG} step_kind_t;

	typedef struct packed {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		dim_t                 reg_val;
		in_item_t             px;
		logic                 typed;
		logic                 hit;
		index_t               idx;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	dim_t                 cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;

	// crop configuration as seen by the predictor
	dim_t crop_w = DIM_RESET;
	dim_t crop_h = DIM_RESET;

	out_item_t pending_writes [$];
	bit        steady = 1'b0;
	int        errors = 0;
	int        n_pixels = 0;
	int        n_writes = 0;
	int        n_reg_writes = 0;

	center_crop_nearest_downscaler #(
		.OUT_SIDE(THUMB_SIDE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#(CLK_PERIOD / 2);
		clk = 1'b0;
		#(CLK_PERIOD / 2);
	end

	// table rows
	function automatic step_t set_reg(logic [CFG_IDX_W-1:0] ri, dim_t v);
		step_t s;
		s = '0;
		s.kind = STEP_CONFIG;
		s.reg_idx = ri;
		s.reg_val = v;
		return s;
	endfunction

	function automatic step_t known_pixel(coord_t x, coord_t y, pixel_t p, logic hit, index_t idx);
		step_t s;
		s = '0;
		s.kind = STEP_PIXEL;
		s.px.src_x = x;
		s.px.src_y = y;
		s.px.pixel_value = p;
		s.typed = 1'b1;
		s.hit = hit;
		s.idx = idx;
		return s;
	endfunction

	function automatic step_t any_pixel(coord_t x, coord_t y, pixel_t p);
		step_t s;
		s = known_pixel(x, y, p, 1'b0, '0);
		s.typed = 1'b0;
		return s;
	endfunction

	step_t script [SCRIPT_LEN] = '{
		// reset dimensions 64x64: identity mapping
		known_pixel(12'd0, 12'd0, 16'h0000, 1'b1, 12'd0),
		known_pixel(12'd63, 12'd63, 16'hFFFF, 1'b1, 12'd4095),
		known_pixel(12'd63, 12'd0, 16'h5555, 1'b1, 12'd63),
		known_pixel(12'd0, 12'd63, 16'hAAAA, 1'b1, 12'd4032),
		known_pixel(12'd64, 12'd0, 16'h1234, 1'b0, 12'd0),
		known_pixel(12'd0, 12'd64, 16'h4321, 1'b0, 12'd0),
		known_pixel(12'd4095, 12'd4095, 16'hFFFF, 1'b0, 12'd0),
		any_pixel(12'd17, 12'd40, 16'hF81F),
		// one row strip: single pixel crop in the middle column
		set_reg(REG_IMAGE_WIDTH, 12'd4095),
		set_reg(REG_IMAGE_HEIGHT, 12'd1),
		known_pixel(12'd2047, 12'd0, 16'h07E0, 1'b1, 12'd0),
		known_pixel(12'd2046, 12'd0, 16'hFFFF, 1'b0, 12'd0),
		known_pixel(12'd2048, 12'd0, 16'hFFFF, 1'b0, 12'd0),
		known_pixel(12'd2047, 12'd1, 16'hFFFF, 1'b0, 12'd0),
		// one column strip
		set_reg(REG_IMAGE_WIDTH, 12'd1),
		set_reg(REG_IMAGE_HEIGHT, 12'd4095),
		known_pixel(12'd0, 12'd2047, 16'h001F, 1'b1, 12'd0),
		known_pixel(12'd1, 12'd2047, 16'h001F, 1'b0, 12'd0),
		known_pixel(12'd0, 12'd2048, 16'h001F, 1'b0, 12'd0),
		// zero width: nothing maps
		set_reg(REG_IMAGE_WIDTH, 12'd0),
		known_pixel(12'd0, 12'd0, 16'hFFFF, 1'b0, 12'd0),
		set_reg(REG_UNUSED, 12'd4095),
		known_pixel(12'd0, 12'd2047, 16'h8000, 1'b0, 12'd0),
		// landscape crop with scaling
		set_reg(REG_IMAGE_WIDTH, 12'd100),
		set_reg(REG_IMAGE_HEIGHT, 12'd60),
		any_pixel(12'd20, 12'd0, 16'h0001),
		any_pixel(12'd19, 12'd0, 16'h0002),
		any_pixel(12'd79, 12'd59, 16'h0004),
		any_pixel(12'd80, 12'd59, 16'h0008),
		any_pixel(12'd50, 12'd30, 16'hC3C3),
		// portrait crop, then full size
		set_reg(REG_IMAGE_HEIGHT, 12'd4095),
		any_pixel(12'd99, 12'd2096, 16'h0FF0),
		any_pixel(12'd0, 12'd1997, 16'hF00F),
		set_reg(REG_IMAGE_WIDTH, 12'd4095),
		any_pixel(12'd4094, 12'd4094, 16'h7BEF)
	};

	// one axis of the nearest neighbor mapping
	function automatic logic scale_axis(int unsigned s, int unsigned off, int unsigned side,
			output int unsigned d);
		d = 0;
		if (side == 0 || s < off || s >= off + side)
			return 1'b0;
		d = ((s - off) * THUMB_SIDE) / side;
		return 1'b1;
	endfunction

	// thumbnail write caused by a source pixel, if it lies in the crop
	function automatic logic thumb_write(in_item_t px, output out_item_t wr);
		int unsigned side, off_x, off_y, dx, dy;
		side = (crop_w < crop_h) ? crop_w : crop_h;
		off_x = (crop_w - side) / 2;
		off_y = (crop_h - side) / 2;
		wr = '0;
		if (!scale_axis(px.src_y, off_y, side, dy))
			return 1'b0;
		if (!scale_axis(px.src_x, off_x, side, dx))
			return 1'b0;
		wr.dest_index = index_t'(dy * THUMB_SIDE + dx);
		wr.dest_pixel = px.pixel_value;
		return 1'b1;
	endfunction

	// coordinate on or just beyond a crop border
	function automatic coord_t near_border(int unsigned lo, int unsigned side);
		case ($urandom_range(0, 3))
			0: return coord_t'(lo - 1);
			1: return coord_t'(lo);
			2: return coord_t'(lo + side - 1);
			default: return coord_t'(lo + side);
		endcase
	endfunction

	// mostly pixels inside the crop, some at its borders, some anywhere
	function automatic in_item_t pick_pixel();
		in_item_t    px;
		int unsigned side, ox, oy, r;
		side = (crop_w < crop_h) ? crop_w : crop_h;
		ox = (crop_w - side) / 2;
		oy = (crop_h - side) / 2;
		r = $urandom_range(0, 99);
		px.pixel_value = pixel_t'($urandom);
		if (side == 0 || r < 15) begin
			px.src_x = coord_t'($urandom);
			px.src_y = coord_t'($urandom);
		end else if (r < 30) begin
			px.src_x = near_border(ox, side);
			px.src_y = ($urandom_range(0, 1) == 1) ? near_border(oy, side)
				: coord_t'(oy + $urandom_range(0, side - 1));
		end else begin
			px.src_x = coord_t'(ox + $urandom_range(0, side - 1));
			px.src_y = coord_t'(oy + $urandom_range(0, side - 1));
		end
		return px;
	endfunction

	// stop sending until every write has come out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_writes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] ri, dim_t v);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (ri)
			REG_IMAGE_WIDTH: crop_w = v;
			REG_IMAGE_HEIGHT: crop_h = v;
			default: ;
		endcase
		n_reg_writes++;
	endtask

	// one pixel transfer, expectation queued once it is accepted
	task automatic push_pixel(in_item_t px, logic typed, logic typed_hit, index_t typed_idx);
		out_item_t wr;
		logic      hit;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (!in_ready);
		if (typed) begin
			hit = typed_hit;
			wr.dest_index = typed_idx;
			wr.dest_pixel = px.pixel_value;
		end else begin
			hit = thumb_write(px, wr);
		end
		if (hit)
			pending_writes.push_back(wr);
		n_pixels++;
	endtask

	// result side backpressure
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// compare each write transfer with the oldest expectation
	always @(posedge clk) begin : check_writes
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected write: expected none, got index %0d pixel %h",
					$time, out_data.dest_index, out_data.dest_pixel);
				errors++;
			end else begin
				want = pending_writes.pop_front();
				if (out_data.dest_index !== want.dest_index) begin
					$display("%0t: dest_index mismatch: expected %0d, got %0d",
						$time, want.dest_index, out_data.dest_index);
					errors++;
				end
				if (out_data.dest_pixel !== want.dest_pixel) begin
					$display("%0t: dest_pixel mismatch: expected %h, got %h",
						$time, want.dest_pixel, out_data.dest_pixel);
					errors++;
				end
				n_writes++;
			end
		end
	end

	// stimulus
	initial begin
		int unsigned w, h;
		cfg_valid <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (script[i]) begin
			if (script[i].kind == STEP_CONFIG)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				push_pixel(script[i].px, script[i].typed, script[i].hit, script[i].idx);
		end

		// random pixels, one crop setting per phase
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin w = 4095; h = 4095; end
				1: begin w = 1; h = 1; end
				2: begin w = $urandom_range(1, 160); h = $urandom_range(1, 160); end
				3: begin w = 4095; h = $urandom_range(1, 4095); end
				4: begin w = $urandom_range(1, 4095); h = 0; end
				5: begin w = $urandom_range(1, 4095); h = $urandom_range(1, 4095); end
				6: begin w = $urandom_range(1, 128); h = $urandom_range(1, 4095); end
				default: begin w = 64; h = 64; end
			endcase
			write_reg(REG_IMAGE_WIDTH, dim_t'(w));
			write_reg(REG_IMAGE_HEIGHT, dim_t'(h));
			// one phase runs with no idling on either side
			steady = (phase == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 5 && k == PHASE_ITEMS / 2)
					settle();
				push_pixel(pick_pixel(), 1'b0, 1'b0, '0);
			end
		end
		steady = 1'b0;
		settle();

		$display("covered %0d source pixels, %0d thumbnail writes, %0d register writes",
			n_pixels, n_writes, n_reg_writes);
		$display("crops: reset size, 1x1, full 4095, strips, zero height, random shapes");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("%0t: timeout with %0d writes outstanding", $time, pending_writes.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
sv/ccnd_pkg.sv
sv/ccnd_cell.sv
sv/center_crop_nearest_downscaler.sv
verif/center_crop_nearest_downscaler_tb.sv
